@@ rtl/core/keyframe_2d_interpolator_core_defines.svh @@
// Assertion macros for the core module.
`ifndef KEYFRAME_2D_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_2D_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define KF2D_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define KF2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kf2d_pkg.sv @@
package kf2d_pkg;

    // key table depth, fixed by the 4-bit entry index and position
    localparam int KEY_DEPTH = 16;

    // Q1.16 unity
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    // constant term 10 * 2^16 of the easing polynomial
    localparam logic [20:0] POLY_BIAS = 21'd655360;

    // configuration register indexes
    localparam logic [7:0] CFG_KEY_COUNT   = 8'd0;
    localparam logic [7:0] CFG_LOOP_ENABLE = 8'd1;
    localparam logic [7:0] CFG_LOOP_INDEX  = 8'd2;
    localparam logic [7:0] CFG_INTERP_MODE = 8'd3;

    // input item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // interpolation modes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_SMOOTH = 1'b1;

    typedef struct packed {
        logic        [31:0] tm;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } key_entry_t;

endpackage

@@ rtl/core/keyframe_2d_interpolator_core.sv @@
// Channel | Ports                                   | Direction
// s_      | s_valid s_ready s_func s_entry_*        | in  (write or tick transaction)
//         | s_delta_ms                              |
// m_      | m_valid m_ready m_out_x m_out_y         | out (one result per tick)
//         | m_current_key m_at_end m_table_empty    |
// cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | in  (register write, always ready)
//
// A write transaction is stored from the idle state. A tick runs from accept to result through
// search read and compare, key reads, ease setup, x/y blend and result load, plus steps
// per keyframe passed, for a loop, for the t division when the time lies strictly between
// keys and for smootherstep; holding the final key skips the division, ease and blend.
// The steps run in series, set by the one key table read port and the shared multiplier.
// Reset (aresetn low, synchronous) clears position, elapsed time and registers;
// the key table is not cleared. The result register lets a new transaction in
// while a result waits; the sequencer stalls only to load a result over a full one.
`include "keyframe_2d_interpolator_core_defines.svh"

module keyframe_2d_interpolator_core
    import kf2d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic        [3:0]  s_entry_index,
    input  logic        [31:0] s_entry_time,
    input  logic signed [31:0] s_entry_x,
    input  logic signed [31:0] s_entry_y,
    input  logic        [15:0] s_delta_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic        [3:0]  m_current_key,
    output logic               m_at_end,
    output logic               m_table_empty,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [7:0]  cfg_index,
    input  logic        [31:0] cfg_data
);

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [8:0] DEPTH_W9 = 9'(KEY_DEPTH);

    typedef logic [AW-1:0] addr_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_LOOP, S_LOOP_OVER, S_LOOP_SET,
        S_GET_A, S_GET_B, S_DIV, S_EASE, S_T3, S_POLY, S_SCALE, S_CLAMP,
        S_MIX_X, S_MIX_Y, S_MIX_DONE, S_OUT
    } state_t;

    // key table, registered read
    key_entry_t mem [KEY_DEPTH];
    key_entry_t rd_q;
    addr_t      rd_addr;
    logic       mem_we;

    state_t state_reg, state_next;
    logic [4:0]  key_count_reg, key_count_next;
    logic        loop_en_reg, loop_en_next;
    logic [3:0]  loop_idx_reg, loop_idx_next;
    logic        mode_reg, mode_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  last_reg, last_next;
    logic [31:0] elapsed_reg, elapsed_next;
    key_entry_t  a_reg, a_next;
    key_entry_t  b_reg, b_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] w_reg, w_next;
    logic [16:0] aux_reg, aux_next;
    logic [20:0] p_reg, p_next;
    logic signed [54:0] prod_reg, prod_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;
    logic        oend_reg, oend_next, oempty_reg, oempty_next;
    logic        m_valid_reg, m_valid_next;
    logic signed [31:0] m_x_reg, m_x_next, m_y_reg, m_y_next;
    logic [3:0]  m_key_reg, m_key_next;
    logic        m_end_reg, m_end_next, m_empty_reg, m_empty_next;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_t'(s_entry_index)] <= '{tm: s_entry_time, x: s_entry_x, y: s_entry_y};
        end
        rd_q <= mem[rd_addr];
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_out_x       = m_x_reg;
    assign m_out_y       = m_y_reg;
    assign m_current_key = m_key_reg;
    assign m_at_end      = m_end_reg;
    assign m_table_empty = m_empty_reg;

    // sequencer
    always_comb begin
        logic [8:0]  n9;
        logic [32:0] sum33;
        logic [32:0] r2;
        logic [31:0] over;
        logic [3:0]  lp;
        logic [21:0] poly;
        logic signed [54:0] sh;

        state_next     = state_reg;
        key_count_next = key_count_reg;
        loop_en_next   = loop_en_reg;
        loop_idx_next  = loop_idx_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        elapsed_next   = elapsed_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        w_next         = w_reg;
        aux_next       = aux_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oend_next      = oend_reg;
        oempty_next    = oempty_reg;
        m_valid_next   = m_valid_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_key_next     = m_key_reg;
        m_end_next     = m_end_reg;
        m_empty_next   = m_empty_reg;
        rd_addr        = addr_t'(pos_reg);
        mem_we         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        n9             = '0;
        sum33          = '0;
        r2             = '0;
        over           = '0;
        lp             = '0;
        poly           = '0;
        sh             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // register writes
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_COUNT:   key_count_next = cfg_data[4:0];
                CFG_LOOP_ENABLE: loop_en_next   = cfg_data[0];
                CFG_LOOP_INDEX:  loop_idx_next  = cfg_data[3:0];
                CFG_INTERP_MODE: mode_next      = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_WRITE) begin
                        mem_we = ({5'b0, s_entry_index} < DEPTH_W9);
                    end else begin
                        n9 = ({4'b0, key_count_reg} < DEPTH_W9) ?
                             {4'b0, key_count_reg} : DEPTH_W9;
                        if (n9 == 9'd0) begin
                            ox_next     = '0;
                            oy_next     = '0;
                            oend_next   = 1'b0;
                            oempty_next = 1'b1;
                            state_next  = S_OUT;
                        end else begin
                            last_next   = 4'(n9 - 9'd1);
                            sum33       = {1'b0, elapsed_reg} + {17'b0, s_delta_ms};
                            elapsed_next = sum33[32] ? '1 : sum33[31:0];
                            pos_next    = (pos_reg > 4'(n9 - 9'd1)) ? 4'(n9 - 9'd1) : pos_reg;
                            oempty_next = 1'b0;
                            state_next  = S_SRCH_RD;
                        end
                    end
                end
            end
            // key search: read next key, then compare
            S_SRCH_RD: begin
                rd_addr = addr_t'(pos_reg + 4'd1);
                state_next = (pos_reg >= last_reg) ? S_LOOP : S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (elapsed_reg >= rd_q.tm) begin
                    pos_next   = pos_reg + 4'd1;
                    state_next = S_SRCH_RD;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                rd_addr = addr_t'(pos_reg);
                state_next = (loop_en_reg && pos_reg >= last_reg) ? S_LOOP_OVER : S_GET_A;
            end
            // loop back carrying the overshoot
            S_LOOP_OVER: begin
                over = (elapsed_reg > rd_q.tm) ? elapsed_reg - rd_q.tm : '0;
                lp   = (loop_idx_reg > last_reg) ? last_reg : loop_idx_reg;
                elapsed_next = over;
                pos_next     = lp;
                rd_addr      = addr_t'(lp);
                state_next   = S_LOOP_SET;
            end
            S_LOOP_SET: begin
                sum33 = {1'b0, rd_q.tm} + {1'b0, elapsed_reg};
                elapsed_next = sum33[32] ? '1 : sum33[31:0];
                rd_addr    = addr_t'(pos_reg);
                state_next = S_GET_A;
            end
            S_GET_A: begin
                a_next = rd_q;
                if (pos_reg >= last_reg) begin
                    ox_next    = rd_q.x;
                    oy_next    = rd_q.y;
                    oend_next  = 1'b1;
                    state_next = S_OUT;
                end else begin
                    rd_addr    = addr_t'(pos_reg + 4'd1);
                    oend_next  = 1'b0;
                    state_next = S_GET_B;
                end
            end
            // clamp t or set up the division
            S_GET_B: begin
                b_next = rd_q;
                if (elapsed_reg >= rd_q.tm) begin
                    w_next     = ONE_Q16;
                    state_next = S_EASE;
                end else if (elapsed_reg <= a_reg.tm) begin
                    w_next     = '0;
                    state_next = S_EASE;
                end else begin
                    rem_next   = elapsed_reg - a_reg.tm;
                    den_next   = rd_q.tm - a_reg.tm;
                    cnt_next   = '0;
                    w_next     = '0;
                    state_next = S_DIV;
                end
            end
            // restoring division, one quotient bit per cycle
            S_DIV: begin
                r2 = {rem_reg, 1'b0};
                if (r2 >= {1'b0, den_reg}) begin
                    rem_next = 32'(r2 - {1'b0, den_reg});
                    w_next   = {w_reg[15:0], 1'b1};
                end else begin
                    rem_next = r2[31:0];
                    w_next   = {w_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = S_EASE;
                end
            end
            S_EASE: begin
                if (mode_reg == MODE_LINEAR) begin
                    state_next = S_MIX_X;
                end else begin
                    mul_a      = {17'b0, w_reg};
                    mul_b      = {4'b0, w_reg};
                    prod_next  = mul_a * mul_b;
                    state_next = S_T3;
                end
            end
            S_T3: begin
                aux_next   = prod_reg[32:16];
                mul_a      = {17'b0, prod_reg[32:16]};
                mul_b      = {4'b0, w_reg};
                prod_next  = mul_a * mul_b;
                state_next = S_POLY;
            end
            S_POLY: begin
                poly = {2'b0, aux_reg, 2'b0} + {3'b0, aux_reg, 1'b0} + {1'b0, POLY_BIAS}
                     - ({1'b0, w_reg, 4'b0} - {5'b0, w_reg});
                p_next     = poly[20:0];
                aux_next   = prod_reg[32:16];
                state_next = S_SCALE;
            end
            S_SCALE: begin
                mul_a      = {17'b0, aux_reg};
                mul_b      = p_reg;
                prod_next  = mul_a * mul_b;
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                w_next     = (prod_reg[54:16] > {22'b0, ONE_Q16}) ? ONE_Q16 : prod_reg[32:16];
                state_next = S_MIX_X;
            end
            // blend x then y
            S_MIX_X: begin
                mul_a      = 34'(33'(b_reg.x) - 33'(a_reg.x));
                mul_b      = {4'b0, w_reg};
                prod_next  = mul_a * mul_b;
                state_next = S_MIX_Y;
            end
            S_MIX_Y: begin
                sh         = prod_reg >>> 16;
                ox_next    = a_reg.x + sh[31:0];
                mul_a      = 34'(33'(b_reg.y) - 33'(a_reg.y));
                mul_b      = {4'b0, w_reg};
                prod_next  = mul_a * mul_b;
                state_next = S_MIX_DONE;
            end
            S_MIX_DONE: begin
                sh         = prod_reg >>> 16;
                oy_next    = a_reg.y + sh[31:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_x_next     = ox_reg;
                    m_y_next     = oy_reg;
                    m_key_next   = oempty_reg ? 4'd0 : pos_reg;
                    m_end_next   = oend_reg;
                    m_empty_next = oempty_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            key_count_reg <= '0;
            loop_en_reg   <= 1'b0;
            loop_idx_reg  <= '0;
            mode_reg      <= MODE_LINEAR;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            loop_en_reg   <= loop_en_next;
            loop_idx_reg  <= loop_idx_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            elapsed_reg   <= elapsed_next;
            m_valid_reg   <= m_valid_next;
        end
        last_reg    <= last_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        cnt_reg     <= cnt_next;
        w_reg       <= w_next;
        aux_reg     <= aux_next;
        p_reg       <= p_next;
        prod_reg    <= prod_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oend_reg    <= oend_next;
        oempty_reg  <= oempty_next;
        m_x_reg     <= m_x_next;
        m_y_reg     <= m_y_next;
        m_key_reg   <= m_key_next;
        m_end_reg   <= m_end_next;
        m_empty_reg <= m_empty_next;
    end

    `KF2D_ASSERT_IMPL(a_div_rem, (state_reg == S_DIV), (rem_reg < den_reg), "division remainder not below divisor")
    `KF2D_ASSERT_IMPL(a_weight_max, (state_reg == S_MIX_X), (w_reg <= ONE_Q16), "blend weight above one")
    `KF2D_ASSERT_IMPL(a_empty_zero, (m_valid_reg && m_empty_reg), (m_x_reg == 0 && m_y_reg == 0 && m_key_reg == 4'd0 && !m_end_reg), "empty table result not zero")
    `KF2D_ASSERT_NEXT(a_pos_range, (state_reg != S_IDLE && !oempty_reg), (pos_reg <= last_reg), "key position beyond final key")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import kf2d_pkg::*;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic        [3:0]  ck;
        logic               end_f;
        logic               empty_f;
    } pose_t;

    // Keyframe track predictor and queue of expected poses
    class pose_scoreboard;
        logic [31:0] tms [16];
        logic [31:0] xs  [16];
        logic [31:0] ys  [16];
        logic [3:0]  pos;
        logic [31:0] elapsed;
        logic [4:0]  key_count;
        logic        loop_en;
        logic [3:0]  loop_idx;
        logic        mode;
        pose_t       pending [$];
        int          errors;
        int          ticks_seen;

        function new();
            pos = 0; elapsed = 0; key_count = 0; loop_en = 0; loop_idx = 0;
            mode = MODE_LINEAR; errors = 0; ticks_seen = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [31:0] v);
            case (idx)
                CFG_KEY_COUNT:   key_count = v[4:0];
                CFG_LOOP_ENABLE: loop_en = v[0];
                CFG_LOOP_INDEX:  loop_idx = v[3:0];
                CFG_INTERP_MODE: mode = v[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [16:0] ease(logic [16:0] t);
            logic [63:0] t2, t3, p, s;
            if (mode == MODE_LINEAR) return t;
            t2 = (64'(t) * t) >> 16;
            t3 = (t2 * t) >> 16;
            p = 6 * t2 + 64'(POLY_BIAS) - 15 * 64'(t);
            s = (t3 * p) >> 16;
            return (s > 64'(ONE_Q16)) ? ONE_Q16 : s[16:0];
        endfunction

        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [16:0] s);
            longint sa, d, pr, r;
            sa = longint'($signed(a));
            d = longint'($signed(b)) - sa;
            pr = d * longint'({1'b0, s});
            r = sa + (pr >>> 16);
            return r[31:0];
        endfunction

        function void note_input(logic func, logic [3:0] ei, logic [31:0] et,
                                 logic [31:0] ex, logic [31:0] ey, logic [15:0] dm);
            pose_t e;
            int n, last, p, lp;
            logic [31:0] over, num_hi;
            logic [16:0] t, s;
            logic [47:0] num;
            if (func == FUNC_WRITE) begin
                tms[ei] = et; xs[ei] = ex; ys[ei] = ey;
                return;
            end
            n = (key_count > 16) ? 16 : key_count;
            e.ox = 0; e.oy = 0; e.ck = 0; e.end_f = 0; e.empty_f = 1;
            if (n == 0) begin
                pending.push_back(e);
                return;
            end
            e.empty_f = 0;
            last = n - 1;
            elapsed = sat_add(elapsed, {16'd0, dm});
            p = (pos > last) ? last : pos;
            while (p < last && elapsed >= tms[p+1]) p++;
            if (loop_en && p >= last) begin
                over = (elapsed > tms[p]) ? elapsed - tms[p] : 0;
                lp = (loop_idx > last) ? last : loop_idx;
                elapsed = sat_add(tms[lp], over);
                p = lp;
            end
            if (p >= last) begin
                e.ox = xs[p]; e.oy = ys[p]; e.end_f = 1;
            end else begin
                if (elapsed >= tms[p+1]) t = ONE_Q16;
                else if (elapsed <= tms[p]) t = 0;
                else begin
                    num = {elapsed - tms[p], 16'd0};
                    num = num / (tms[p+1] - tms[p]);
                    t = (num > 48'(ONE_Q16)) ? ONE_Q16 : num[16:0];
                end
                s = ease(t);
                e.ox = blend(xs[p], xs[p+1], s);
                e.oy = blend(ys[p], ys[p+1], s);
            end
            pos = p[3:0];
            e.ck = pos;
            pending.push_back(e);
        endfunction

        function void check_result(pose_t a);
            pose_t e;
            ticks_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h", $time, a.ox, a.oy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ox !== e.ox) begin
                $display("%0t: out_x expected %h actual %h", $time, e.ox, a.ox); errors++;
            end
            if (a.oy !== e.oy) begin
                $display("%0t: out_y expected %h actual %h", $time, e.oy, a.oy); errors++;
            end
            if (a.ck !== e.ck) begin
                $display("%0t: current_key expected %0d actual %0d", $time, e.ck, a.ck);
                errors++;
            end
            if (a.end_f !== e.end_f) begin
                $display("%0t: at_end expected %b actual %b", $time, e.end_f, a.end_f);
                errors++;
            end
            if (a.empty_f !== e.empty_f) begin
                $display("%0t: table_empty expected %b actual %b", $time, e.empty_f,
                         a.empty_f);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, s_func = 0;
    logic [3:0] s_entry_index = 0;
    logic [31:0] s_entry_time = 0;
    logic signed [31:0] s_entry_x = 0, s_entry_y = 0;
    logic [15:0] s_delta_ms = 0;
    logic m_valid, m_ready = 0;
    logic signed [31:0] m_out_x, m_out_y;
    logic [3:0] m_current_key;
    logic m_at_end, m_table_empty;
    logic cfg_valid = 0, cfg_ready;
    logic [7:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;

    pose_scoreboard sb = new();
    int cycles = 0;
    int hold_off = 0;
    int items_sent = 0;
    bit rx_random = 1;

    keyframe_2d_interpolator_core u_top (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("keyframe_2d_interpolator_core regression: fail");
            $finish;
        end
    end

    // Result side: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_out_x, m_out_y, m_current_key, m_at_end, m_table_empty});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else if (rx_random)
            m_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        else
            m_ready <= 1;
    end

    // Input valid stays up after a transaction until the next driver call lowers it
    task automatic write_reg(logic [7:0] idx, logic [31:0] v);
        s_valid <= 0;
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic send(logic func, logic [3:0] ei, logic [31:0] et,
                        logic [31:0] ex, logic [31:0] ey, logic [15:0] dm, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 3) : 0;
        cfg_valid <= 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1; s_func <= func; s_entry_index <= ei; s_entry_time <= et;
        s_entry_x <= ex; s_entry_y <= ey; s_delta_ms <= dm;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(func, ei, et, ex, ey, dm);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 0;
        cfg_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Load n keys with nondecreasing times and random extreme-ish values
    task automatic load_track(int n, int max_step, bit gaps);
        logic [31:0] tm, x, y;
        tm = $urandom_range(0, 50);
        for (int i = 0; i < n; i++) begin
            x = $urandom; y = $urandom;
            if ($urandom_range(0, 7) == 0) x = 32'h8000_0000;
            if ($urandom_range(0, 7) == 0) y = 32'h7FFF_FFFF;
            send(FUNC_WRITE, i[3:0], tm, x, y, 16'($urandom), gaps);
            tm = tm + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, max_step));
        end
    endtask

    task automatic configure(int n, bit le, int li, bit md);
        write_reg(CFG_KEY_COUNT, n);
        write_reg(CFG_LOOP_ENABLE, le);
        write_reg(CFG_LOOP_INDEX, li);
        write_reg(CFG_INTERP_MODE, md);
    endtask

    initial begin
        int n, li;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty table, then extremes of fields and times
        send(FUNC_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
        drain();
        configure(2, 0, 0, MODE_LINEAR);
        send(FUNC_WRITE, 0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send(FUNC_WRITE, 1, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send(FUNC_WRITE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 16'd0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 16'd333, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 16'd667, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
        drain();
        write_reg(CFG_INTERP_MODE, MODE_SMOOTH);
        write_reg(CFG_LOOP_ENABLE, 1);
        // equal times, loop to index beyond final key, count beyond written keys avoided
        send(FUNC_WRITE, 1, 32'd0, 32'h1234_5678, 32'hF000_0000, 0, 0);
        send(FUNC_TICK, 0, 0, 0, 0, 16'd5, 0);
        drain();
        write_reg(CFG_LOOP_INDEX, 15);
        send(FUNC_WRITE, 1, 32'd70000, 32'h0001_0000, 32'hFFFF_0000, 0, 0);
        for (int i = 0; i < 5; i++) send(FUNC_TICK, 0, 0, 0, 0, 16'hFFFF, 0);
        drain();
        // key count lowered under position: stale position clamp, then 16 keys
        write_reg(CFG_KEY_COUNT, 1);
        send(FUNC_TICK, 0, 0, 0, 0, 16'd1, 0);
        drain();
        load_track(16, 40, 0);
        configure(16, 0, 0, MODE_SMOOTH);
        for (int i = 0; i < 4; i++) send(FUNC_TICK, 0, 0, 0, 0, 16'($urandom_range(0, 30)), 0);
        drain();

        // Random phases; elapsed carries across phases as in the block
        for (int ph = 0; ph < 24; ph++) begin
            n = (ph % 6 == 0) ? 16 : $urandom_range(0, 6);
            li = (ph % 5 == 0) ? 15 : $urandom_range(0, 15);
            // only ever read written slots
            load_track((n == 0) ? 1 : n, (ph % 4 == 0) ? 60000 : 200, 1);
            drain();
            configure(n, $urandom_range(0, 1), li, $urandom_range(0, 1));
            if (ph == 3) hold_off = 400;
            for (int k = 0; k < 15; k++)
                send(FUNC_TICK, 0, 0, 0, 0,
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 120)), ph != 3);
            if ($urandom_range(0, 3) == 0)
                send(FUNC_WRITE, 4'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                     16'($urandom), 1);
            // sender pause until every result is in
            drain();
            rx_random = (ph % 7 != 2);
        end
        drain();
        $display("covered %0d transactions, %0d results, empty/linear/smooth/loop/clamp cases",
                 items_sent, sb.ticks_seen);
        $display("register settings varied over 24 phases with long output stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("keyframe_2d_interpolator_core regression: pass");
        else
            $display("keyframe_2d_interpolator_core regression: fail");
        $finish;
    end
endmodule

@@ keyframe_2d_interpolator_core.f @@
+incdir+rtl/core
rtl/core/kf2d_pkg.sv
rtl/core/keyframe_2d_interpolator_core.sv
tb/sv/tb_top.sv
